// ===== design/usc_pkg.sv =====
// Shared types and constants for the Unix-seconds-to-calendar converter.
// Holds the config struct, register index codes and the reciprocal divide constants.
// No dependencies.
`default_nettype none

package usc_pkg;

    // Calendar constants
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_SHIFT    = 719468;
    localparam int unsigned DAYS_PER_ERA  = 146097;
    localparam int unsigned DOE_LAST      = 146096;
    localparam int unsigned DAYS_4Y       = 1460;
    localparam int unsigned DAYS_100Y     = 36524;
    localparam int unsigned YEARS_PER_ERA = 400;

    // 32-bit time spans only two eras after the day shift
    localparam int unsigned ERA_LO        = DAYS_SHIFT / DAYS_PER_ERA;
    localparam int unsigned ERA_HI_DAY    = (ERA_LO + 1) * DAYS_PER_ERA - DAYS_SHIFT;
    localparam int unsigned ERA_LO_DOE    = DAYS_SHIFT - ERA_LO * DAYS_PER_ERA;
    localparam int unsigned YEAR_ERA_LO   = ERA_LO * YEARS_PER_ERA;
    localparam int unsigned YEAR_ERA_HI   = (ERA_LO + 1) * YEARS_PER_ERA;

    // Pipeline depth: accepting edge to result-accepting edge
    localparam int unsigned LAT = 11;

    // Reciprocal constants: floor(x/D) = (x*M) >> S, M = ceil(2^S/D), S = xbits + log2(D)
    // seconds -> days: t/86400 = (t>>7)/675
    localparam int unsigned DAY_SH = 7;
    localparam int unsigned DAY_D  = SECS_PER_DAY >> DAY_SH;
    localparam int unsigned DAY_S  = 35;
    localparam logic [25:0] DAY_M  =
        26'(((64'd1 << DAY_S) + 64'(DAY_D) - 64'd1) / 64'(DAY_D));

    // seconds of day -> hour: sod/3600 = (sod>>4)/225
    localparam int unsigned HR_SH = 4;
    localparam int unsigned HR_D  = SECS_PER_HOUR >> HR_SH;
    localparam int unsigned HR_S  = 21;
    localparam logic [13:0] HR_M  =
        14'(((64'd1 << HR_S) + 64'(HR_D) - 64'd1) / 64'(HR_D));

    // seconds of hour -> minute: rem/60 = (rem>>2)/15
    localparam int unsigned MN_SH = 2;
    localparam int unsigned MN_D  = SECS_PER_MIN >> MN_SH;
    localparam int unsigned MN_S  = 14;
    localparam logic [10:0] MN_M  =
        11'(((64'd1 << MN_S) + 64'(MN_D) - 64'd1) / 64'(MN_D));

    // weekday quotient: (days+4)/7
    localparam int unsigned WD_D  = 7;
    localparam int unsigned WD_S  = 19;
    localparam logic [16:0] WD_M  =
        17'(((64'd1 << WD_S) + 64'(WD_D) - 64'd1) / 64'(WD_D));

    // doe/1460
    localparam int unsigned Q4_S  = 29;
    localparam logic [18:0] Q4_M  =
        19'(((64'd1 << Q4_S) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    // year of era: x/365
    localparam int unsigned DAYS_Y = 365;
    localparam int unsigned YR_S   = 27;
    localparam logic [18:0] YR_M   =
        19'(((64'd1 << YR_S) + 64'(DAYS_Y) - 64'd1) / 64'(DAYS_Y));

    // yoe/100
    localparam int unsigned C_D   = 100;
    localparam int unsigned C_S   = 16;
    localparam logic [9:0]  C_M   =
        10'(((64'd1 << C_S) + 64'(C_D) - 64'd1) / 64'(C_D));

    // month index: (5*doy+2)/153 folded into one multiply-add
    localparam int unsigned MP_D  = 153;
    localparam int unsigned MP_S  = 19;
    localparam logic [11:0] MP_M  =
        12'(((64'd1 << MP_S) + 64'(MP_D) - 64'd1) / 64'(MP_D));
    localparam logic [14:0] MP_A  = 15'(5 * MP_M);
    localparam logic [23:0] MP_B  = 24'(2 * MP_M);

    // month start: (153*mp+2)/5 folded into one multiply-add
    localparam int unsigned DY_D  = 5;
    localparam int unsigned DY_S  = 14;
    localparam logic [11:0] DY_M  =
        12'(((64'd1 << DY_S) + 64'(DY_D) - 64'd1) / 64'(DY_D));
    localparam logic [18:0] DY_A  = 19'(MP_D * DY_M);
    localparam logic [23:0] DY_B  = 24'(2 * DY_M);

    // Register index codes (paddr[2])
    typedef enum logic {
        REG_SYNC_OFFSET = 1'b0,
        REG_TZ_HOURS    = 1'b1
    } t_usc_reg;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [31:0] sync_offset;
        logic [5:0]  tz_hours;
    } t_usc_cfg;

endpackage

`default_nettype wire

// ===== design/usc_regs.sv =====
// APB configuration registers of the calendar converter: sync offset and timezone.
// Depends on usc_pkg (register codes, config struct).
`default_nettype none

module usc_regs
    import usc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_usc_cfg    o_cfg
);

    logic        wr_en;
    t_usc_reg    reg_sel;
    logic [31:0] r_sync_offset;
    logic [5:0]  r_tz_hours;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = t_usc_reg'(paddr[2]);

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_offset <= '0;
            r_tz_hours    <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SYNC_OFFSET: r_sync_offset <= pwdata;
                REG_TZ_HOURS:    r_tz_hours    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_SYNC_OFFSET: prdata = r_sync_offset;
            REG_TZ_HOURS:    prdata = {26'd0, r_tz_hours};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.sync_offset = r_sync_offset;
    assign o_cfg.tz_hours    = r_tz_hours;

endmodule

`default_nettype wire

// ===== design/usc_pipe.sv =====
// Eleven-stage datapath: local time sum, day split, era/day-of-era, civil date.
// Constant divides use reciprocal multiplies. Depends on usc_pkg.
`default_nettype none

module usc_pipe
    import usc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_vld,
    input  wire  [31:0] i_uptime_seconds,
    input  t_usc_cfg    i_cfg,
    output logic        o_vld,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic [2:0]  o_wday
);

    // valid bit per stage
    logic [LAT-1:0] r_vld;

    // stage 1: local time
    logic signed [17:0] tz_sec;
    logic [31:0] n_s1_t, r_s1_t;

    // stage 2: day count
    logic [50:0] day_prod;
    logic [15:0] n_s2_days, r_s2_days;
    logic [16:0] r_s2_tlo;

    // stage 3: second of day, day of era, weekday quotient
    logic [16:0] n_s3_sod, r_s3_sod;
    logic        n_s3_era5, r_s3_era5;
    logic [17:0] n_s3_doe, r_s3_doe;
    logic [15:0] r_s3_days4;
    logic [32:0] wd_prod;
    logic [12:0] n_s3_wdq, r_s3_wdq;

    // stage 4: hour, leap corrections, weekday
    logic [26:0] hr_prod;
    logic [36:0] q4_prod;
    logic [4:0]  n_s4_hour, r_s4_hour;
    logic [6:0]  n_s4_a, r_s4_a;
    logic [2:0]  n_s4_b, r_s4_b;
    logic        n_s4_c, r_s4_c;
    logic [2:0]  n_s4_wday, r_s4_wday;
    logic [16:0] r_s4_sod;
    logic [17:0] r_s4_doe;
    logic        r_s4_era5;

    // stage 5: second of hour, leap-adjusted day of era
    logic [11:0] n_s5_rem, r_s5_rem;
    logic [17:0] n_s5_x, r_s5_x;
    logic [4:0]  r_s5_hour;
    logic [17:0] r_s5_doe;
    logic        r_s5_era5;
    logic [2:0]  r_s5_wday;

    // stage 6: minute, year of era
    logic [20:0] mn_prod;
    logic [36:0] yr_prod;
    logic [5:0]  n_s6_minute, r_s6_minute;
    logic [8:0]  n_s6_yoe, r_s6_yoe;
    logic [11:0] r_s6_rem;
    logic [4:0]  r_s6_hour;
    logic [17:0] r_s6_doe;
    logic        r_s6_era5;
    logic [2:0]  r_s6_wday;

    // stage 7: second, century count
    logic [18:0] c_prod;
    logic [5:0]  n_s7_second, r_s7_second;
    logic [1:0]  n_s7_yq100, r_s7_yq100;
    logic [5:0]  r_s7_minute;
    logic [4:0]  r_s7_hour;
    logic [17:0] r_s7_doe;
    logic        r_s7_era5;
    logic [8:0]  r_s7_yoe;
    logic [2:0]  r_s7_wday;

    // stage 8: day of year
    logic [17:0] yr_start;
    logic [8:0]  n_s8_doy, r_s8_doy;
    logic [5:0]  r_s8_second, r_s8_minute;
    logic [4:0]  r_s8_hour;
    logic        r_s8_era5;
    logic [8:0]  r_s8_yoe;
    logic [2:0]  r_s8_wday;

    // stage 9: month index
    logic [23:0] mp_prod;
    logic [3:0]  n_s9_mp, r_s9_mp;
    logic [8:0]  r_s9_doy;
    logic [5:0]  r_s9_second, r_s9_minute;
    logic [4:0]  r_s9_hour;
    logic        r_s9_era5;
    logic [8:0]  r_s9_yoe;
    logic [2:0]  r_s9_wday;

    // stage 10: month start, month, year
    logic [23:0] dy_prod;
    logic [8:0]  n_s10_q5, r_s10_q5;
    logic [3:0]  n_s10_month, r_s10_month;
    logic [11:0] n_s10_year, r_s10_year;
    logic        jan_feb;
    logic [8:0]  r_s10_doy;
    logic [5:0]  r_s10_second, r_s10_minute;
    logic [4:0]  r_s10_hour;
    logic [2:0]  r_s10_wday;

    // stage 11: output registers
    logic [4:0]  n_s11_day, r_s11_day;
    logic [5:0]  r_s11_second, r_s11_minute;
    logic [4:0]  r_s11_hour;
    logic [3:0]  r_s11_month;
    logic [11:0] r_s11_year;
    logic [2:0]  r_s11_wday;

    // stage 1: uptime + offset + timezone, wraps mod 2^32
    assign tz_sec = 18'($signed(i_cfg.tz_hours) * $signed(18'(SECS_PER_HOUR)));
    assign n_s1_t = i_uptime_seconds + i_cfg.sync_offset + 32'(tz_sec);

    // stage 2: days = t / 86400
    assign day_prod  = 51'(r_s1_t[31:DAY_SH]) * 51'(DAY_M);
    assign n_s2_days = 16'(day_prod >> DAY_S);

    // stage 3: sod by low-bit subtract, era select, weekday quotient
    assign n_s3_sod  = r_s2_tlo - 17'(17'(r_s2_days) * 17'(SECS_PER_DAY));
    assign n_s3_era5 = (r_s2_days >= 16'(ERA_HI_DAY));
    assign n_s3_doe  = n_s3_era5 ? (18'(r_s2_days) - 18'(ERA_HI_DAY))
                                 : (18'(r_s2_days) + 18'(ERA_LO_DOE));
    // (days+4)*M = days*M + 4*M
    assign wd_prod   = 33'(r_s2_days) * 33'(WD_M) + 33'(4 * WD_M);
    assign n_s3_wdq  = 13'(wd_prod >> WD_S);

    // stage 4
    assign hr_prod   = 27'(r_s3_sod[16:HR_SH]) * 27'(HR_M);
    assign n_s4_hour = 5'(hr_prod >> HR_S);
    assign q4_prod   = 37'(r_s3_doe) * 37'(Q4_M);
    assign n_s4_a    = 7'(q4_prod >> Q4_S);
    assign n_s4_b    = 3'(r_s3_doe >= 18'(DAYS_100Y))
                     + 3'(r_s3_doe >= 18'(2 * DAYS_100Y))
                     + 3'(r_s3_doe >= 18'(3 * DAYS_100Y))
                     + 3'(r_s3_doe >= 18'(4 * DAYS_100Y));
    assign n_s4_c    = (r_s3_doe >= 18'(DOE_LAST));
    assign n_s4_wday = r_s3_days4[2:0] - 3'(3'(r_s3_wdq) * 3'(WD_D));

    // stage 5
    assign n_s5_rem = r_s4_sod[11:0] - 12'(12'(r_s4_hour) * 12'(SECS_PER_HOUR));
    assign n_s5_x   = r_s4_doe - 18'(r_s4_a) + 18'(r_s4_b) - 18'(r_s4_c);

    // stage 6
    assign mn_prod     = 21'(r_s5_rem[11:MN_SH]) * 21'(MN_M);
    assign n_s6_minute = 6'(mn_prod >> MN_S);
    assign yr_prod     = 37'(r_s5_x) * 37'(YR_M);
    assign n_s6_yoe    = 9'(yr_prod >> YR_S);

    // stage 7
    assign n_s7_second = r_s6_rem[5:0] - 6'(r_s6_minute * 6'(SECS_PER_MIN));
    assign c_prod      = 19'(r_s6_yoe) * 19'(C_M);
    assign n_s7_yq100  = 2'(c_prod >> C_S);

    // stage 8: doy = doe - (365*yoe + yoe/4 - yoe/100)
    assign yr_start = 18'(r_s7_yoe) * 18'(DAYS_Y) + 18'(r_s7_yoe >> 2)
                    - 18'(r_s7_yq100);
    assign n_s8_doy = 9'(r_s7_doe - yr_start);

    // stage 9
    assign mp_prod = 24'(r_s8_doy) * 24'(MP_A) + MP_B;
    assign n_s9_mp = 4'(mp_prod >> MP_S);

    // stage 10: month and civil year
    assign dy_prod     = 24'(r_s9_mp) * 24'(DY_A) + DY_B;
    assign n_s10_q5    = 9'(dy_prod >> DY_S);
    assign jan_feb     = (r_s9_mp >= 4'd10);
    assign n_s10_month = jan_feb ? (r_s9_mp - 4'd9) : (r_s9_mp + 4'd3);
    assign n_s10_year  = (r_s9_era5 ? 12'(YEAR_ERA_HI) : 12'(YEAR_ERA_LO))
                       + 12'(r_s9_yoe) + 12'(jan_feb);

    // stage 11: day of month, true value 1..31 so low bits suffice
    assign n_s11_day = r_s10_doy[4:0] - r_s10_q5[4:0] + 5'd1;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], i_vld};
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        r_s1_t       <= n_s1_t;

        r_s2_days    <= n_s2_days;
        r_s2_tlo     <= r_s1_t[16:0];

        r_s3_sod     <= n_s3_sod;
        r_s3_era5    <= n_s3_era5;
        r_s3_doe     <= n_s3_doe;
        r_s3_days4   <= r_s2_days + 16'd4;
        r_s3_wdq     <= n_s3_wdq;

        r_s4_hour    <= n_s4_hour;
        r_s4_a       <= n_s4_a;
        r_s4_b       <= n_s4_b;
        r_s4_c       <= n_s4_c;
        r_s4_wday    <= n_s4_wday;
        r_s4_sod     <= r_s3_sod;
        r_s4_doe     <= r_s3_doe;
        r_s4_era5    <= r_s3_era5;

        r_s5_rem     <= n_s5_rem;
        r_s5_x       <= n_s5_x;
        r_s5_hour    <= r_s4_hour;
        r_s5_doe     <= r_s4_doe;
        r_s5_era5    <= r_s4_era5;
        r_s5_wday    <= r_s4_wday;

        r_s6_minute  <= n_s6_minute;
        r_s6_yoe     <= n_s6_yoe;
        r_s6_rem     <= r_s5_rem;
        r_s6_hour    <= r_s5_hour;
        r_s6_doe     <= r_s5_doe;
        r_s6_era5    <= r_s5_era5;
        r_s6_wday    <= r_s5_wday;

        r_s7_second  <= n_s7_second;
        r_s7_yq100   <= n_s7_yq100;
        r_s7_minute  <= r_s6_minute;
        r_s7_hour    <= r_s6_hour;
        r_s7_doe     <= r_s6_doe;
        r_s7_era5    <= r_s6_era5;
        r_s7_yoe     <= r_s6_yoe;
        r_s7_wday    <= r_s6_wday;

        r_s8_doy     <= n_s8_doy;
        r_s8_second  <= r_s7_second;
        r_s8_minute  <= r_s7_minute;
        r_s8_hour    <= r_s7_hour;
        r_s8_era5    <= r_s7_era5;
        r_s8_yoe     <= r_s7_yoe;
        r_s8_wday    <= r_s7_wday;

        r_s9_mp      <= n_s9_mp;
        r_s9_doy     <= r_s8_doy;
        r_s9_second  <= r_s8_second;
        r_s9_minute  <= r_s8_minute;
        r_s9_hour    <= r_s8_hour;
        r_s9_era5    <= r_s8_era5;
        r_s9_yoe     <= r_s8_yoe;
        r_s9_wday    <= r_s8_wday;

        r_s10_q5     <= n_s10_q5;
        r_s10_month  <= n_s10_month;
        r_s10_year   <= n_s10_year;
        r_s10_doy    <= r_s9_doy;
        r_s10_second <= r_s9_second;
        r_s10_minute <= r_s9_minute;
        r_s10_hour   <= r_s9_hour;
        r_s10_wday   <= r_s9_wday;

        r_s11_day    <= n_s11_day;
        r_s11_second <= r_s10_second;
        r_s11_minute <= r_s10_minute;
        r_s11_hour   <= r_s10_hour;
        r_s11_month  <= r_s10_month;
        r_s11_year   <= r_s10_year;
        r_s11_wday   <= r_s10_wday;
    end

    assign o_vld    = r_vld[LAT-1];
    assign o_second = r_s11_second;
    assign o_minute = r_s11_minute;
    assign o_hour   = r_s11_hour;
    assign o_day    = r_s11_day;
    assign o_month  = r_s11_month;
    assign o_year   = r_s11_year;
    assign o_wday   = r_s11_wday;

`ifndef SYNTH
    // every accepted item reaches the output
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ##(LAT) o_vld)
        else $error("accepted item did not reach output");

    // no result without a matching accept
    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(i_vld, LAT))
        else $error("result without accepted item");

    // time-of-day and weekday fields stay in range
    a_time_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_second < 6'd60) && (o_minute < 6'd60)
                  && (o_hour < 5'd24) && (o_wday < 3'd7))
        else $error("time field out of range");

    // date split stays in range
    a_date_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day >= 5'd1)
                  && !((o_month == 4'd2) && (o_day > 5'd29)))
        else $error("date field out of range");
`endif

endmodule

`default_nettype wire

// ===== design/unix_seconds_to_calendar.sv =====
// A transfer accepted at one edge passes through every pipeline stage register before its result strobe.
// Throughput: one transfer per cycle; busy stays low, the eleven-stage pipeline sets the rate.
// Reset (synchronous, active low) clears the pipeline valid bits and both config registers.
// Depends on usc_pkg, usc_regs and usc_pipe.
`default_nettype none

module unix_seconds_to_calendar
    import usc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command side
    input  wire         start,
    output logic        busy,
    input  wire  [31:0] i_uptime_seconds,
    // result side
    output logic        o_valid,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic [2:0]  o_weekday
);

    t_usc_cfg cfg;
    logic     in_xfer;

    // fully pipelined, never stalls
    assign busy    = 1'b0;
    assign in_xfer = start & ~busy;

    usc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    usc_pipe u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (in_xfer),
        .i_uptime_seconds (i_uptime_seconds),
        .i_cfg            (cfg),
        .o_vld            (o_valid),
        .o_second         (o_second),
        .o_minute         (o_minute),
        .o_hour           (o_hour),
        .o_day            (o_day_of_month),
        .o_month          (o_month),
        .o_year           (o_year),
        .o_wday           (o_weekday)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_unix_seconds_to_calendar.sv =====
// Self-checking testbench for unix_seconds_to_calendar: APB register writes, uptime
// transfers with random sender gaps, and a date predictor that checks every result.
// Depends on usc_pkg and the unix_seconds_to_calendar RTL.

module tb_unix_seconds_to_calendar
    import usc_pkg::*;
();

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  wday;
    } t_cal_date;

    // Tracks register values, predicts each date and checks results in order
    class date_checker;
        logic [31:0] sync_offset;
        logic [5:0]  tz_hours;
        t_cal_date   pending_dates[$];
        int          mismatches;

        function new();
            sync_offset = '0;
            tz_hours    = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(t_usc_reg which, logic [31:0] value);
            case (which)
                REG_SYNC_OFFSET: sync_offset = value;
                REG_TZ_HOURS:    tz_hours    = value[5:0];
                default: ;
            endcase
        endfunction

        // sync offset plus signed timezone seconds, wrapped to 32 bits
        function logic [31:0] offset();
            logic [31:0] tz_sec;
            tz_sec = 32'(int'($signed(tz_hours)) * int'(SECS_PER_HOUR));
            return sync_offset + tz_sec;
        endfunction

        // Days-to-civil conversion on the local time
        function t_cal_date to_calendar(logic [31:0] uptime);
            int unsigned t, days, z, era, doe, yoe, doy, mp, d, m, y;
            t_cal_date   r;
            t    = uptime + offset();
            days = t / SECS_PER_DAY;
            z    = days + DAYS_SHIFT;
            era  = z / DAYS_PER_ERA;
            doe  = z - era * DAYS_PER_ERA;
            yoe  = (doe - doe / DAYS_4Y + doe / DAYS_100Y - doe / DOE_LAST) / 365;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            d    = doy - (153 * mp + 2) / 5 + 1;
            m    = (mp < 10) ? mp + 3 : mp - 9;
            y    = era * YEARS_PER_ERA + yoe + ((m <= 2) ? 1 : 0);
            r.sec    = 6'(t % 60);
            r.minute = 6'((t / 60) % 60);
            r.hour   = 5'((t / SECS_PER_HOUR) % 24);
            r.mday   = 5'(d);
            r.month  = 4'(m);
            r.year   = 12'(y);
            r.wday   = 3'((days + 4) % 7);
            return r;
        endfunction

        function void note_uptime(logic [31:0] uptime);
            pending_dates.push_back(to_calendar(uptime));
        endfunction

        function void field_cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_date(t_cal_date got);
            t_cal_date exp_d;
            if (pending_dates.size() == 0) begin
                $display("%0t: result with none expected, got %p", $time, got);
                mismatches++;
                return;
            end
            exp_d = pending_dates.pop_front();
            field_cmp("second", exp_d.sec, got.sec);
            field_cmp("minute", exp_d.minute, got.minute);
            field_cmp("hour", exp_d.hour, got.hour);
            field_cmp("day_of_month", exp_d.mday, got.mday);
            field_cmp("month", exp_d.month, got.month);
            field_cmp("year", exp_d.year, got.year);
            field_cmp("weekday", exp_d.wday, got.wday);
        endfunction
    endclass

    // Local times at era, leap-day, century and year boundaries
    localparam logic [31:0] LANDMARKS [7] = '{
        32'd0, 32'd63072000, 32'd68256000, 32'd946684800,
        32'd951868800, 32'd4107542400, 32'd4291833600
    };
    localparam logic [31:0] DIRECTED [22] = '{
        32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
        32'd86400, 32'd68255999, 32'd68256000, 32'd946684799, 32'd946684800,
        32'd951868799, 32'd951868800, 32'd4107542399, 32'd4107542400,
        32'd4291833599, 32'd4291833600, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA
    };
    localparam int IDLE_PCT [3] = '{0, 80, 13};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [31:0] i_uptime_seconds;
    logic        o_valid;
    logic [5:0]  o_second;
    logic [5:0]  o_minute;
    logic [4:0]  o_hour;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month;
    logic [11:0] o_year;
    logic [2:0]  o_weekday;

    date_checker cal;

    unix_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_uptime_seconds(i_uptime_seconds),
        .o_valid         (o_valid),
        .o_second        (o_second),
        .o_minute        (o_minute),
        .o_hour          (o_hour),
        .o_day_of_month  (o_day_of_month),
        .o_month         (o_month),
        .o_year          (o_year),
        .o_weekday       (o_weekday)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Result side: every strobe is a transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            cal.check_date(t_cal_date'{o_second, o_minute, o_hour, o_day_of_month,
                                       o_month, o_year, o_weekday});
    end

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(t_usc_reg which, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cal.set_reg(which, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One uptime transfer, after a random number of idle cycles
    task automatic send_uptime(logic [31:0] uptime, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start            <= 1'b0;
            i_uptime_seconds <= $urandom();
        end
        @(negedge i_clk);
        start            <= 1'b1;
        i_uptime_seconds <= uptime;
        do @(posedge i_clk); while (busy);
        cal.note_uptime(uptime);
    endtask

    // Drop start and wait for every outstanding date
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (cal.pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    // Half fully random, half aimed near a day, hour or calendar boundary
    function automatic logic [31:0] pick_uptime();
        logic [31:0] target;
        if ($urandom_range(1))
            return $urandom();
        case ($urandom_range(2))
            0:       target = LANDMARKS[$urandom_range(6)];
            1:       target = ($urandom() / SECS_PER_DAY) * SECS_PER_DAY;
            default: target = ($urandom() / SECS_PER_HOUR) * SECS_PER_HOUR;
        endcase
        return target - cal.offset() + $urandom_range(200) - 100;
    endfunction

    initial begin
        cal              = new();
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        start            = 1'b0;
        i_uptime_seconds = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes and calendar boundaries at reset settings
        foreach (DIRECTED[k])
            send_uptime(DIRECTED[k], 0);
        // Negative timezone before the epoch wraps to 2106
        drain();
        write_reg(REG_TZ_HOURS, 32'h3F);
        send_uptime(32'd0, 0);
        send_uptime(32'd3599, 0);

        // Random: each sender-gap profile under several register settings
        for (int ph = 0; ph < 3; ph++) begin
            for (int k = 0; k < 4; k++) begin
                drain();
                case (k)
                    0: begin
                        write_reg(REG_SYNC_OFFSET, $urandom());
                        write_reg(REG_TZ_HOURS, $urandom_range(63));
                    end
                    1: begin
                        write_reg(REG_SYNC_OFFSET, 32'hFFFF_FFFF);
                        write_reg(REG_TZ_HOURS, 32'h20);
                    end
                    2: begin
                        write_reg(REG_SYNC_OFFSET, 32'h0);
                        write_reg(REG_TZ_HOURS, (ph == 1) ? 32'h28 : 32'd24);
                    end
                    default: begin
                        write_reg(REG_SYNC_OFFSET, $urandom());
                        write_reg(REG_TZ_HOURS, (ph == 0) ? 32'd31 : $urandom_range(63));
                    end
                endcase
                for (int n = 0; n < 50; n++)
                    send_uptime(pick_uptime(), IDLE_PCT[ph]);
            end
        end

        drain();
        repeat (LAT + 4) @(posedge i_clk);
        if (cal.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit, far beyond the slowest correct run
    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/usc_pkg.sv
design/usc_regs.sv
design/usc_pipe.sv
design/unix_seconds_to_calendar.sv
tb/sv/tb_unix_seconds_to_calendar.sv
